// File: rtl/twpg_pkg.sv
package twpg_pkg;

  localparam int ID_W    = 32;
  localparam int STAMP_W = 48;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic [STAMP_W-1:0] TIME_WINDOW_RESET = 48'd100000;

  // register index is paddr[3]: registers sit 8 bytes apart
  localparam logic REG_TIME_WINDOW = 1'b0;

  typedef struct packed {
    logic [ID_W-1:0]    req_id;
    logic [STAMP_W-1:0] timestamp;
  } twpg_in_t;

  typedef struct packed {
    logic [ID_W-1:0] earlier_id;
    logic [ID_W-1:0] new_id;
    logic            last;
  } twpg_out_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] stamp;
  } twpg_entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_LOAD
  } twpg_cell_op_t;

  typedef struct packed {
    twpg_cell_op_t op;
    logic          hit;
  } twpg_cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_ROTATE,
    ST_FINISH
  } twpg_state_t;

endpackage

// File: rtl/twpg_cell.sv
module twpg_cell (
  input  logic                     clk,
  input  twpg_pkg::twpg_cell_ctrl_t ctrl,
  input  twpg_pkg::twpg_entry_t    right,
  input  twpg_pkg::twpg_entry_t    wrap,
  input  twpg_pkg::twpg_entry_t    fresh,
  output twpg_pkg::twpg_entry_t    q
);
  import twpg_pkg::*;

  twpg_entry_t entry;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_SHIFT: entry <= right;
      CELL_ROTATE: begin
        // the hit cell, the last occupied one, closes the ring by taking the head entry
        if (ctrl.hit) begin
          entry <= wrap;
        end else begin
          entry <= right;
        end
      end
      CELL_LOAD: begin
        if (ctrl.hit) begin
          entry <= fresh;
        end
      end
      default: entry <= entry;
    endcase
  end

  assign q = entry;

endmodule

// File: rtl/time_window_pair_generator.sv
// Channel | Direction | Handshake            | Beat
// in      | input     | in_valid / in_ready  | twpg_in_t (req_id, timestamp)
// out     | output    | out_valid / out_ready| twpg_out_t (earlier_id, new_id, last)
// apb     | input     | psel / penable       | time_window at paddr 0, 64-bit data
//
// One request runs through accept, E evictions (one shift of the cell row
// each), a decide step, N rotation steps over the older entries, the end of
// rotation and the append; a drop for a full window doubles as the decide step.
// The row of WINDOW_DEPTH cells shifts or rotates by one slot per cycle while not held.
// Reset clears the control state and sets time_window to 100000; cells are
// not cleared. A rotation step that must place a pair waits while the output
// register holds a beat that is not taken; so does the final append.
module time_window_pair_generator #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  twpg_pkg::twpg_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output twpg_pkg::twpg_out_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twpg_pkg::PADDR_W-1:0]    paddr,
  input  logic [twpg_pkg::PDATA_W-1:0]    pwdata,
  output logic [twpg_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import twpg_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // configuration
  logic [STAMP_W-1:0] time_window;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_window <= TIME_WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr[3] == REG_TIME_WINDOW) begin
      time_window <= pwdata[STAMP_W-1:0];
    end
  end

  assign prdata = (paddr[3] == REG_TIME_WINDOW) ?
                  {{(PDATA_W-STAMP_W){1'b0}}, time_window} : '0;

  // control state
  twpg_state_t       state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  rot_left;
  logic              pend_valid;
  logic [ID_W-1:0]   pend_id;
  logic [ID_W-1:0]   cur_id;
  logic [STAMP_W-1:0] cur_stamp;

  twpg_entry_t       cell_q [WINDOW_DEPTH];
  twpg_entry_t       fresh;
  twpg_cell_op_t     cell_op;
  logic [IDX_W-1:0]  sel_idx;

  logic              push, push_last, load_pend, clear_pend, cnt_dec, cnt_inc, rot_step;
  logic              out_free, differ, too_far, evict_go, step_ok, finish_ok;
  logic              head_ge;
  logic [STAMP_W-1:0] stamp_dist;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign fresh    = '{id: cur_id, stamp: cur_stamp};

  // distance from the oldest entry to the current request
  assign head_ge    = cell_q[0].stamp >= cur_stamp;
  assign stamp_dist = head_ge ? (cell_q[0].stamp - cur_stamp)
                              : (cur_stamp - cell_q[0].stamp);
  assign too_far    = stamp_dist > time_window;
  assign differ     = cell_q[0].id != cur_id;

  assign evict_go  = (count != '0) && too_far;
  assign step_ok   = !differ || !pend_valid || out_free;
  assign finish_ok = !pend_valid || out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        // a drop for a full window ends eviction without a new check
        if (!evict_go) begin
          state_next = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        if (rot_left == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cell_op    = CELL_HOLD;
    sel_idx    = '0;
    push       = 1'b0;
    push_last  = 1'b0;
    load_pend  = 1'b0;
    clear_pend = 1'b0;
    cnt_dec    = 1'b0;
    cnt_inc    = 1'b0;
    rot_step   = 1'b0;
    case (state)
      ST_EVICT: begin
        if (evict_go || count == CNT_FULL) begin
          cell_op = CELL_SHIFT;
          cnt_dec = 1'b1;
        end
      end
      ST_ROTATE: begin
        if (rot_left != '0 && step_ok) begin
          cell_op  = CELL_ROTATE;
          sel_idx  = IDX_W'(count - CNT_ONE);
          rot_step = 1'b1;
          if (differ) begin
            // hold the new pair back until we know whether it is the last
            load_pend = 1'b1;
            push      = pend_valid;
          end
        end
      end
      ST_FINISH: begin
        if (finish_ok) begin
          cell_op    = CELL_LOAD;
          sel_idx    = count[IDX_W-1:0];
          cnt_inc    = 1'b1;
          push       = pend_valid;
          push_last  = 1'b1;
          clear_pend = 1'b1;
        end
      end
      default: cell_op = CELL_HOLD;
    endcase
  end

  always_comb begin
    count_next = count;
    if (cnt_dec) begin
      count_next = count - CNT_ONE;
    end else if (cnt_inc) begin
      count_next = count + CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      rot_left   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_EVICT) begin
        rot_left <= count_next;
      end else if (rot_step) begin
        rot_left <= rot_left - CNT_ONE;
      end
      if (load_pend) begin
        pend_valid <= 1'b1;
      end else if (clear_pend) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_id    <= in_data.req_id;
      cur_stamp <= in_data.timestamp;
    end
    if (load_pend) begin
      pend_id <= cell_q[0].id;
    end
    if (push) begin
      out_data <= '{earlier_id: pend_id, new_id: cur_id, last: push_last};
    end
  end

  // row of window cells, oldest entry in cell 0
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    twpg_cell_ctrl_t ctrl;
    twpg_entry_t     right;

    assign ctrl.op  = cell_op;
    assign ctrl.hit = (IDX_W'(k) == sel_idx);

    if (k == WINDOW_DEPTH - 1) begin : g_tail
      assign right = fresh;
    end else begin : g_body
      assign right = cell_q[k+1];
    end

    twpg_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .right (right),
      .wrap  (cell_q[0]),
      .fresh (fresh),
      .q     (cell_q[k])
    );
  end

endmodule

// File: rtl/twpg_checker.sv
module twpg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input twpg_pkg::twpg_out_t          out_data,
  input logic [twpg_pkg::PDATA_W-1:0] prdata,
  input logic                         pready
);
  import twpg_pkg::*;

  // a stalled output beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // one request at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous request in flight");

  // pairs never join a block with itself
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.earlier_id != out_data.new_id)
    else $error("pair with equal ids");

  // register reads carry 48 bits, always ready
  assert property (@(posedge clk) disable iff (rst)
    pready && prdata[PDATA_W-1:STAMP_W] == '0)
    else $error("config port read or ready wrong");

endmodule

bind time_window_pair_generator twpg_checker u_twpg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .prdata    (prdata),
  .pready    (pready)
);
